[src/pcm_sample_playback_16ch_defines.svh]
// Assertion macros used by the sample player controller.
// Needs clk and rst_n in the scope of each use.
`ifndef PCM_SAMPLE_PLAYBACK_16CH_DEFINES_SVH
`define PCM_SAMPLE_PLAYBACK_16CH_DEFINES_SVH

// same-cycle implication
`define PSP16_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psp16 assertion failed");

// next-cycle implication
`define PSP16_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psp16 assertion failed");

`endif

[src/psp16_pkg.sv]
// Shared types, constants and helpers of the sample player.
// No dependencies.
`default_nettype none
package psp16_pkg;

  localparam int ROM_ADDR_BITS = 19;
  localparam int CHANNELS      = 16;
  localparam int CHAN_BITS     = 4;
  localparam int RAM_BITS      = 11;
  localparam int RAM_DEPTH     = 2048;
  localparam int ACC_BITS      = 21;
  localparam int NUM_KEYS      = 9;

  typedef logic [ROM_ADDR_BITS-1:0] rom_addr_t;
  typedef logic [RAM_BITS-1:0]      ram_addr_t;
  typedef logic [CHAN_BITS-1:0]     chan_t;
  typedef logic [3:0]               key_t;

  localparam logic [1:0] OP_REG_WR = 2'd0;
  localparam logic [1:0] OP_REG_RD = 2'd1;
  localparam logic [1:0] OP_ROM_LD = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] CFG_BANK_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_BANK_MASK   = 2'd1;
  localparam logic [1:0] CFG_UPDATE_STEP = 2'd2;

  // per-channel register keys, in read order
  localparam key_t K_FLAGS = 4'd0;
  localparam key_t K_AHI   = 4'd1;
  localparam key_t K_AMID  = 4'd2;
  localparam key_t K_LHI   = 4'd3;
  localparam key_t K_LMID  = 4'd4;
  localparam key_t K_END   = 4'd5;
  localparam key_t K_VL    = 4'd6;
  localparam key_t K_VR    = 4'd7;
  localparam key_t K_PITCH = 4'd8;

  localparam logic [7:0] FLAGS_REG = 8'h86;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] reg_offset;
    logic [18:0] rom_offset;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_word_t;

  typedef enum logic [1:0] {RS_ITEM, RS_CHAN, RS_CLEAR} ram_src_t;
  typedef enum logic [2:0] {W_ITEM, W_FF, W_FLAGS, W_AMID, W_AHI} wsel_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_RD_DONE, ST_RD, ST_RD_LAST, ST_EVAL,
    ST_FETCH, ST_MUL, ST_ACC, ST_WR_MID, ST_WR_HI, ST_TICK_OUT
  } state_t;

  typedef struct packed {
    logic      in_ready;
    logic      ram_rd;
    logic      ram_wr;
    ram_src_t  src;
    ram_addr_t clr_addr;
    key_t      key;
    chan_t     chan;
    wsel_t     wsel;
    logic      latch;
    key_t      latch_key;
    logic      rom_wr;
    logic      rom_rd;
    logic      eval;
    logic      mul;
    logic      acc;
    logic      mix_clr;
    logic      frac_clr;
    logic      frac_wr;
    logic      out_load_rd;
    logic      out_load_tick;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       stopped;
    logic       at_end;
    logic       no_loop;
    logic       out_free;
  } sts_t;

  function automatic logic [7:0] key_offset(input key_t k);
    logic [7:0] o;
    case (k)
      K_FLAGS: o = FLAGS_REG;
      K_AHI:   o = 8'h85;
      K_AMID:  o = 8'h84;
      K_LHI:   o = 8'h05;
      K_LMID:  o = 8'h04;
      K_END:   o = 8'h06;
      K_VL:    o = 8'h02;
      K_VR:    o = 8'h03;
      K_PITCH: o = 8'h07;
      default: o = 8'h00;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

[src/psp16_if.sv]
// Valid/ready channels of the sample player: command words in, results out.
// No dependencies.
`default_nettype none
interface psp16_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [10:0]          reg_offset;
  logic [18:0]          rom_offset;
  logic [7:0]           write_data;
  modport source (output valid, opcode, reg_offset, rom_offset, write_data, input ready);
  modport sink   (input valid, opcode, reg_offset, rom_offset, write_data, output ready);
endinterface

interface psp16_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         read_data;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  modport source (output valid, result_kind, read_data, left_sample, right_sample,
                  input ready);
  modport sink   (input valid, result_kind, read_data, left_sample, right_sample,
                  output ready);
endinterface
`default_nettype wire

[src/psp16_dpath.sv]
// Datapath: register RAM, sample ROM, channel fields, multipliers, mix and output word.
// Depends on psp16_pkg; driven by psp16_ctrl through cmd_t.
`default_nettype none
module psp16_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire psp16_pkg::in_word_t in_word,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  input  wire psp16_pkg::cmd_t    cmd,
  output psp16_pkg::sts_t         sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output psp16_pkg::out_word_t    out_word
);

  logic [7:0] ram_mem_r [psp16_pkg::RAM_DEPTH];
  logic [7:0] rom_mem_r [2**psp16_pkg::ROM_ADDR_BITS];
  logic [7:0] ram_q_r, rom_q_r;

  psp16_pkg::in_word_t item_r;
  logic [4:0]  bank_shift_r;
  logic [7:0]  bank_mask_r;
  logic [19:0] update_step_r;

  logic [7:0] flags_r, ahi_r, amid_r, lhi_r, lmid_r, end_r, vl_r, vr_r, pitch_r;
  logic [7:0] frac_r [psp16_pkg::CHANNELS];
  logic [23:0] addr_r;
  logic signed [17:0] pl_r, pr_r;
  logic [27:0] pstep_r;
  logic signed [psp16_pkg::ACC_BITS-1:0] accl_r, accr_r;

  logic                 out_valid_r;
  psp16_pkg::out_word_t out_r;

  psp16_pkg::ram_addr_t ram_addr;
  logic [7:0]           ram_wdata;
  psp16_pkg::rom_addr_t rom_rd_addr, bank;
  logic signed [8:0]    sample_v;

  always_comb begin
    case (cmd.src)
      psp16_pkg::RS_ITEM:  ram_addr = item_r.reg_offset;
      psp16_pkg::RS_CHAN:  ram_addr = psp16_pkg::ram_addr_t'({cmd.chan, 3'b000})
                                      + psp16_pkg::ram_addr_t'(psp16_pkg::key_offset(cmd.key));
      psp16_pkg::RS_CLEAR: ram_addr = cmd.clr_addr;
      default:             ram_addr = cmd.clr_addr;
    endcase
    case (cmd.wsel)
      psp16_pkg::W_ITEM:  ram_wdata = item_r.write_data;
      psp16_pkg::W_FF:    ram_wdata = 8'hFF;
      psp16_pkg::W_FLAGS: ram_wdata = flags_r | 8'h01;
      psp16_pkg::W_AMID:  ram_wdata = addr_r[15:8];
      psp16_pkg::W_AHI:   ram_wdata = addr_r[23:16];
      default:            ram_wdata = 8'hFF;
    endcase
  end

  assign bank = psp16_pkg::rom_addr_t'(psp16_pkg::rom_addr_t'(flags_r & bank_mask_r)
                                       << bank_shift_r);
  assign rom_rd_addr = bank + psp16_pkg::rom_addr_t'(addr_r[23:8]);
  assign sample_v = $signed({1'b0, rom_q_r}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (cmd.ram_wr) ram_mem_r[ram_addr] <= ram_wdata;
    if (cmd.ram_rd) ram_q_r <= ram_mem_r[ram_addr];
    if (cmd.rom_wr) rom_mem_r[psp16_pkg::rom_addr_t'(item_r.rom_offset)] <= item_r.write_data;
    if (cmd.rom_rd) rom_q_r <= rom_mem_r[rom_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_word;
    if (cmd.latch) begin
      case (cmd.latch_key)
        psp16_pkg::K_FLAGS: flags_r <= ram_q_r;
        psp16_pkg::K_AHI:   ahi_r   <= ram_q_r;
        psp16_pkg::K_AMID:  amid_r  <= ram_q_r;
        psp16_pkg::K_LHI:   lhi_r   <= ram_q_r;
        psp16_pkg::K_LMID:  lmid_r  <= ram_q_r;
        psp16_pkg::K_END:   end_r   <= ram_q_r;
        psp16_pkg::K_VL:    vl_r    <= ram_q_r;
        psp16_pkg::K_VR:    vr_r    <= ram_q_r;
        psp16_pkg::K_PITCH: pitch_r <= ram_q_r;
        default: ;
      endcase
    end
    // take the loop point at the end page, else resume from the current address
    if (cmd.eval) begin
      if (sts.at_end) addr_r <= {lhi_r, lmid_r, 8'h00};
      else            addr_r <= {ahi_r, amid_r, frac_r[cmd.chan]};
    end else if (cmd.acc) begin
      addr_r <= addr_r + 24'(pstep_r[27:16]);
    end
    if (cmd.mul) begin
      pl_r    <= sample_v * $signed({1'b0, vl_r});
      pr_r    <= sample_v * $signed({1'b0, vr_r});
      pstep_r <= pitch_r * update_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_shift_r  <= 5'd12;
      bank_mask_r   <= 8'd112;
      update_step_r <= 20'd65536;
      for (int i = 0; i < psp16_pkg::CHANNELS; i++) frac_r[i] <= 8'h00;
      accl_r        <= '0;
      accr_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psp16_pkg::CFG_BANK_SHIFT:  bank_shift_r  <= cfg_data[4:0];
          psp16_pkg::CFG_BANK_MASK:   bank_mask_r   <= cfg_data[7:0];
          psp16_pkg::CFG_UPDATE_STEP: update_step_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.frac_clr) frac_r[cmd.chan] <= 8'h00;
      else if (cmd.frac_wr) frac_r[cmd.chan] <= addr_r[7:0];
      if (cmd.mix_clr) begin
        accl_r <= '0;
        accr_r <= '0;
      end else if (cmd.acc) begin
        accl_r <= accl_r + psp16_pkg::ACC_BITS'(pl_r);
        accr_r <= accr_r + psp16_pkg::ACC_BITS'(pr_r);
      end
      if (cmd.out_load_rd || cmd.out_load_tick) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [psp16_pkg::ACC_BITS-1:0] v);
    logic signed [15:0] s;
    if (v > psp16_pkg::ACC_BITS'(32767))       s = 16'sh7FFF;
    else if (v < -psp16_pkg::ACC_BITS'(32768)) s = 16'sh8000;
    else                                        s = v[15:0];
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.out_load_rd) begin
      out_r.result_kind  <= 1'b0;
      out_r.read_data    <= ram_q_r;
      out_r.left_sample  <= '0;
      out_r.right_sample <= '0;
    end else if (cmd.out_load_tick) begin
      out_r.result_kind  <= 1'b1;
      out_r.read_data    <= 8'h00;
      out_r.left_sample  <= sat16(accl_r);
      out_r.right_sample <= sat16(accr_r);
    end
  end

  assign sts.op       = item_r.opcode;
  assign sts.stopped  = flags_r[0];
  assign sts.no_loop  = flags_r[1];
  assign sts.at_end   = (ahi_r == 8'(end_r + 8'd1));
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_word     = out_r;

endmodule
`default_nettype wire

[src/psp16_ctrl.sv]
// Controller: sequences register RAM clearing, item execution and the per-channel tick walk.
// Depends on psp16_pkg and the assertion macros header.
`default_nettype none
`include "pcm_sample_playback_16ch_defines.svh"
module psp16_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire psp16_pkg::sts_t sts,
  output psp16_pkg::cmd_t      cmd
);

  psp16_pkg::state_t    state_r, state_nxt;
  psp16_pkg::ram_addr_t clr_r, clr_nxt;
  psp16_pkg::chan_t     chan_r, chan_nxt;
  psp16_pkg::key_t      kidx_r, kidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psp16_pkg::ST_CLEAR;
      clr_r   <= '0;
      chan_r  <= '0;
      kidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      chan_r  <= chan_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_comb begin
    logic last_chan;
    last_chan = (chan_r == psp16_pkg::chan_t'(psp16_pkg::CHANNELS - 1));
    state_nxt = state_r;
    clr_nxt   = clr_r;
    chan_nxt  = chan_r;
    kidx_nxt  = kidx_r;
    cmd           = '0;
    cmd.src       = psp16_pkg::RS_CHAN;
    cmd.wsel      = psp16_pkg::W_FF;
    cmd.clr_addr  = clr_r;
    cmd.chan      = chan_r;
    cmd.key       = kidx_r;
    case (state_r)
      psp16_pkg::ST_CLEAR: begin
        cmd.ram_wr = 1'b1;
        cmd.src    = psp16_pkg::RS_CLEAR;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == psp16_pkg::ram_addr_t'(psp16_pkg::RAM_DEPTH - 1))
          state_nxt = psp16_pkg::ST_IDLE;
      end
      psp16_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) state_nxt = psp16_pkg::ST_EXEC;
      end
      psp16_pkg::ST_EXEC: begin
        cmd.src = psp16_pkg::RS_ITEM;
        case (sts.op)
          psp16_pkg::OP_REG_WR: begin
            cmd.ram_wr = 1'b1;
            cmd.wsel   = psp16_pkg::W_ITEM;
            state_nxt  = psp16_pkg::ST_IDLE;
          end
          psp16_pkg::OP_REG_RD: begin
            cmd.ram_rd = 1'b1;
            state_nxt  = psp16_pkg::ST_RD_DONE;
          end
          psp16_pkg::OP_ROM_LD: begin
            cmd.rom_wr = 1'b1;
            state_nxt  = psp16_pkg::ST_IDLE;
          end
          default: begin
            cmd.mix_clr = 1'b1;
            chan_nxt    = '0;
            kidx_nxt    = '0;
            state_nxt   = psp16_pkg::ST_RD;
          end
        endcase
      end
      psp16_pkg::ST_RD_DONE: begin
        // hold the read byte until the output register frees up
        if (sts.out_free) begin
          cmd.out_load_rd = 1'b1;
          state_nxt       = psp16_pkg::ST_IDLE;
        end
      end
      psp16_pkg::ST_RD: begin
        cmd.ram_rd    = 1'b1;
        cmd.latch     = (kidx_r != psp16_pkg::K_FLAGS);
        cmd.latch_key = kidx_r - 1'b1;
        if (kidx_r == psp16_pkg::key_t'(psp16_pkg::NUM_KEYS - 1))
          state_nxt = psp16_pkg::ST_RD_LAST;
        else
          kidx_nxt = kidx_r + 1'b1;
      end
      psp16_pkg::ST_RD_LAST: begin
        cmd.latch     = 1'b1;
        cmd.latch_key = kidx_r;
        state_nxt     = psp16_pkg::ST_EVAL;
      end
      psp16_pkg::ST_EVAL: begin
        if (sts.stopped || (sts.at_end && sts.no_loop)) begin
          if (!sts.stopped) begin
            cmd.ram_wr   = 1'b1;
            cmd.key      = psp16_pkg::K_FLAGS;
            cmd.wsel     = psp16_pkg::W_FLAGS;
            cmd.frac_clr = 1'b1;
          end
          kidx_nxt = '0;
          if (last_chan) state_nxt = psp16_pkg::ST_TICK_OUT;
          else begin
            chan_nxt  = chan_r + 1'b1;
            state_nxt = psp16_pkg::ST_RD;
          end
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = psp16_pkg::ST_FETCH;
        end
      end
      psp16_pkg::ST_FETCH: begin
        cmd.rom_rd = 1'b1;
        state_nxt  = psp16_pkg::ST_MUL;
      end
      psp16_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = psp16_pkg::ST_ACC;
      end
      psp16_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = psp16_pkg::ST_WR_MID;
      end
      psp16_pkg::ST_WR_MID: begin
        cmd.ram_wr = 1'b1;
        cmd.key    = psp16_pkg::K_AMID;
        cmd.wsel   = psp16_pkg::W_AMID;
        state_nxt  = psp16_pkg::ST_WR_HI;
      end
      psp16_pkg::ST_WR_HI: begin
        cmd.ram_wr  = 1'b1;
        cmd.key     = psp16_pkg::K_AHI;
        cmd.wsel    = psp16_pkg::W_AHI;
        cmd.frac_wr = 1'b1;
        kidx_nxt    = '0;
        if (last_chan) state_nxt = psp16_pkg::ST_TICK_OUT;
        else begin
          chan_nxt  = chan_r + 1'b1;
          state_nxt = psp16_pkg::ST_RD;
        end
      end
      psp16_pkg::ST_TICK_OUT: begin
        if (sts.out_free) begin
          cmd.out_load_tick = 1'b1;
          state_nxt         = psp16_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psp16_pkg::ST_IDLE;
    endcase
  end

  `PSP16_ASSERT_NOW(a_no_accept_in_clear, state_r == psp16_pkg::ST_CLEAR, !cmd.in_ready)
  `PSP16_ASSERT_NOW(a_out_load_free, cmd.out_load_rd || cmd.out_load_tick, sts.out_free)
  `PSP16_ASSERT_NEXT(a_accept_executes, cmd.in_ready && in_valid, state_r == psp16_pkg::ST_EXEC)

endmodule
`default_nettype wire

[src/pcm_sample_playback_16ch.sv]
// Sixteen-channel PCM sample player, top level.
// Command words arrive on in_ch (valid/ready); each is a register write, a register
// read, a sample ROM byte load or an output tick, picked by opcode.
// Writes and loads give no result word. A read gives one word of kind 0 with the
// register byte; a tick gives one word of kind 1 with the saturated stereo mix.
// Results leave on out_ch through an output register, so a new command word is
// taken while a finished result still waits to be picked up.
// A tick walks the channels one at a time over the single register RAM port;
// a stopped channel or one that halts at its end skips the ROM fetch, mix and
// address write-back that a playing one goes through.
// After reset all 2048 bytes of the register RAM are filled with 0xFF, one
// byte a cycle, with in_ch.ready low; configuration writes are taken throughout.
// If out_ch stalls, the finished result holds in the output register and the next
// word that produces a result waits in its last state until the register frees.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle.
// Depends on psp16_pkg, psp16_if, psp16_ctrl and psp16_dpath.
`default_nettype none
module pcm_sample_playback_16ch (
  input  wire logic        clk,
  input  wire logic        rst_n,
  psp16_in_if.sink         in_ch,
  psp16_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  psp16_pkg::cmd_t      cmd;
  psp16_pkg::sts_t      sts;
  psp16_pkg::in_word_t  in_word;
  psp16_pkg::out_word_t out_word;
  logic                 in_fire;

  assign in_word.opcode     = in_ch.opcode;
  assign in_word.reg_offset = in_ch.reg_offset;
  assign in_word.rom_offset = in_ch.rom_offset;
  assign in_word.write_data = in_ch.write_data;
  assign in_ch.ready        = cmd.in_ready;
  assign in_fire            = in_ch.valid && cmd.in_ready;

  psp16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  psp16_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.result_kind  = out_word.result_kind;
  assign out_ch.read_data    = out_word.read_data;
  assign out_ch.left_sample  = out_word.left_sample;
  assign out_ch.right_sample = out_word.right_sample;

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the sixteen-channel PCM sample player.
// Predicts every read and tick word with a scoreboard class; needs psp16_pkg,
// psp16_if and the pcm_sample_playback_16ch RTL.
`default_nettype none
module testbench;
  import psp16_pkg::*;

  class player_scoreboard;
    logic [7:0]  regs [RAM_DEPTH];
    logic [7:0]  frac [CHANNELS];
    logic [7:0]  rom [1 << ROM_ADDR_BITS];
    bit          rom_loaded [1 << ROM_ADDR_BITS];
    logic [4:0]  shift_amt;
    logic [7:0]  mask_bits;
    logic [19:0] step;
    out_word_t   pending_q [$];
    rom_addr_t   missing_q [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = 8'hFF;
      foreach (frac[i]) frac[i] = 8'h00;
      shift_amt = 5'd12;
      mask_bits = 8'd112;
      step      = 20'd65536;
      errors    = 0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        CFG_BANK_SHIFT:  shift_amt = val[4:0];
        CFG_BANK_MASK:   mask_bits = val[7:0];
        CFG_UPDATE_STEP: step      = val;
        default: ;
      endcase
    endfunction

    // Walk all channels; with commit low leave the state untouched and collect ROM bytes not yet loaded.
    function void mix_all(bit commit, output int lsum, output int rsum);
      int base;
      logic [7:0]  flags, endp;
      logic [63:0] bank;
      logic [23:0] addr, loop_addr;
      rom_addr_t   ra;
      int          v;
      logic [31:0] delta;
      lsum = 0;
      rsum = 0;
      missing_q.delete();
      for (int ch = 0; ch < CHANNELS; ch++) begin
        base  = 8 * ch;
        flags = regs[base + FLAGS_REG];
        if (flags[0]) continue;
        bank      = 64'(flags & mask_bits) << shift_amt;
        addr      = {regs[base + 8'h85], regs[base + 8'h84], frac[ch]};
        loop_addr = {regs[base + 5], regs[base + 4], 8'h00};
        endp      = regs[base + 6] + 8'd1;
        if (addr[23:16] == endp) begin
          if (flags[1]) begin
            if (commit) begin
              regs[base + FLAGS_REG] = flags | 8'h01;
              frac[ch] = 8'h00;
            end
            continue;
          end
          addr = loop_addr;
        end
        ra = rom_addr_t'(bank + 64'(addr[23:8]));
        if (!rom_loaded[ra]) missing_q.push_back(ra);
        v = rom_loaded[ra] ? int'(rom[ra]) - 128 : -128;
        lsum += v * int'(regs[base + 2]);
        rsum += v * int'(regs[base + 3]);
        delta = (32'(regs[base + 7]) * 32'(step)) >> 16;
        addr  = addr + delta[23:0];
        if (commit) begin
          regs[base + 8'h84] = addr[15:8];
          regs[base + 8'h85] = addr[23:16];
          frac[ch] = addr[7:0];
        end
      end
    endfunction

    function logic signed [15:0] sat16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
    endfunction

    function void note_input(in_word_t w);
      out_word_t e;
      int l, r;
      e = '0;
      case (w.opcode)
        OP_REG_WR: regs[w.reg_offset] = w.write_data;
        OP_REG_RD: begin
          e.read_data = regs[w.reg_offset];
          pending_q.push_back(e);
        end
        OP_ROM_LD: begin
          rom[w.rom_offset] = w.write_data;
          rom_loaded[w.rom_offset] = 1'b1;
        end
        default: begin
          mix_all(1'b1, l, r);
          e.result_kind  = 1'b1;
          e.left_sample  = sat16(l);
          e.right_sample = sat16(r);
          pending_q.push_back(e);
        end
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word kind %0d rd %0h l %0d r %0d", $realtime,
                 got.result_kind, got.read_data, got.left_sample, got.right_sample);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch exp kind %0d rd %0h l %0d r %0d / got kind %0d rd %0h l %0d r %0d",
                 $realtime, e.result_kind, e.read_data, e.left_sample, e.right_sample,
                 got.result_kind, got.read_data, got.left_sample, got.right_sample);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  bit          quiet = 1'b0;
  int          sent = 0;

  psp16_in_if  in_ch ();
  psp16_out_if out_ch ();

  player_scoreboard sb = new();

  pcm_sample_playback_16ch u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.reg_offset = '0;
    in_ch.rom_offset = '0;
    in_ch.write_data = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) out_ch.ready <= quiet || ($urandom_range(0, 99) >= 33);

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input({in_ch.opcode, in_ch.reg_offset, in_ch.rom_offset, in_ch.write_data});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.result_kind, out_ch.read_data, out_ch.left_sample,
                       out_ch.right_sample});
  end

  task automatic send_word(logic [1:0] op, logic [10:0] roff, logic [18:0] moff,
                           logic [7:0] data);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.reg_offset = roff;
    in_ch.rom_offset = moff;
    in_ch.write_data = data;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Load every not yet loaded ROM byte the coming tick would fetch, then tick.
  task automatic send_tick();
    int l, r;
    rom_addr_t need [$];
    sb.mix_all(1'b0, l, r);
    need = sb.missing_q;
    foreach (need[i]) send_word(OP_ROM_LD, 11'($urandom), need[i], 8'($urandom));
    send_word(OP_TICK, 11'($urandom), 19'($urandom), 8'($urandom));
  endtask

  task automatic program_channel(int ch, logic [7:0] vl, vr, lhi, lmid, endp, pitch,
                                 ahi, amid, flags);
    logic [7:0] offs [9] = '{8'h02, 8'h03, 8'h05, 8'h04, 8'h06, 8'h07, 8'h85, 8'h84,
                             FLAGS_REG};
    logic [7:0] vals [9];
    vals = '{vl, vr, lhi, lmid, endp, pitch, ahi, amid, flags};
    for (int k = 0; k < 9; k++)
      send_word(OP_REG_WR, 11'(8 * ch + offs[k]), 19'($urandom), vals[k]);
  endtask

  task automatic random_channel();
    logic [7:0] endp, ahi, flags;
    endp = 8'($urandom);
    case ($urandom_range(0, 2))
      0: ahi = endp;
      1: ahi = endp + 8'd1;
      default: ahi = 8'($urandom);
    endcase
    flags = 8'($urandom);
    if ($urandom_range(0, 9) < 8) flags[0] = 1'b0;
    program_channel($urandom_range(0, 15), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), endp, 8'($urandom), ahi, 8'($urandom), flags);
  endtask

  task automatic write_cfg(logic [4:0] sh, logic [7:0] mk, logic [19:0] st);
    logic [1:0]  idx [3] = '{CFG_BANK_SHIFT, CFG_BANK_MASK, CFG_UPDATE_STEP};
    logic [19:0] val [3];
    val = '{20'(sh), 20'(mk), st};
    // drain, then hold off for a full tick so the block is idle
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    for (int k = 0; k < 3; k++) begin
      cfg_we = 1'b1;
      cfg_index = idx[k];
      cfg_data = val[k];
      sb.set_cfg(idx[k], val[k]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  initial begin
    int pick;
    logic [4:0]  sh_set [5] = '{5'd12, 5'd0, 5'd20, 5'd31, 5'd0};
    logic [7:0]  mk_set [5] = '{8'd112, 8'd0, 8'hFF, 8'hFF, 8'h00};
    logic [19:0] st_set [5] = '{20'd65536, 20'd0, 20'hFFFFF, 20'd1, 20'd0};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed opening
    send_word(OP_REG_RD, 11'd0, 19'd0, 8'd0);
    send_word(OP_REG_RD, 11'h7FF, 19'h7FFFF, 8'hFF);
    send_word(OP_REG_WR, 11'h7FF, 19'd0, 8'h00);
    send_word(OP_REG_RD, 11'h7FF, 19'd0, 8'h00);
    send_word(OP_ROM_LD, 11'd0, 19'h7FFFF, 8'hFF);
    send_word(OP_ROM_LD, 11'h7FF, 19'd0, 8'h00);
    send_tick();
    // full volume on a zero byte drives the left mix to negative saturation
    program_channel(0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h02);
    program_channel(15, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00);
    send_tick();
    send_tick();
    send_word(OP_REG_RD, 11'h86, 19'd0, 8'd0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) write_cfg(5'($urandom), 8'($urandom), 20'($urandom));
      else write_cfg(sh_set[ph], mk_set[ph], st_set[ph]);
      quiet = (ph == 2);
      while (sent < 190 * (ph + 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) random_channel();
        else if (pick < 55) send_tick();
        else if (pick < 75) send_word(OP_REG_RD, 11'($urandom), 19'($urandom), 8'($urandom));
        else if (pick < 90) send_word(OP_REG_WR, 11'($urandom), 19'($urandom), 8'($urandom));
        else send_word(OP_ROM_LD, 11'($urandom), 19'($urandom), 8'($urandom));
      end
      quiet = 1'b0;
    end

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
